### hw/rtl/cfzs_pkg.sv
// Package for the camera follow/zoom/shake block: mode codes, register
// indexes, sequencer states and shared helpers. No dependencies.
package cfzs_pkg;

   typedef enum logic [2:0] {
      MODE_TICK   = 3'd0,
      MODE_SHAKE  = 3'd1,
      MODE_STOP   = 3'd2,
      MODE_TARGET = 3'd3,
      MODE_JUMP   = 3'd4,
      MODE_SETPOS = 3'd5,
      MODE_SPARE6 = 3'd6,
      MODE_SPARE7 = 3'd7
   } mode_type;

   localparam logic [2:0] REG_DZ_W   = 3'd0;
   localparam logic [2:0] REG_DZ_H   = 3'd1;
   localparam logic [2:0] REG_GAIN   = 3'd2;
   localparam logic [2:0] REG_BND_W  = 3'd3;
   localparam logic [2:0] REG_BND_H  = 3'd4;
   localparam logic [2:0] REG_AIM_X  = 3'd5;
   localparam logic [2:0] REG_AIM_Y  = 3'd6;
   localparam logic [2:0] REG_ZSTEP  = 3'd7;

   localparam logic [15:0] SEED_RESET = 16'h1234;
   localparam logic [31:0] LCG_MUL    = 32'd1103515245;
   localparam logic [15:0] LCG_ADD    = 16'd12345;
   localparam logic [7:0]  ZOOM_RESET = 8'd128;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ZOOM,
      ST_VIS,
      ST_MULX,
      ST_MULY,
      ST_CLAMP,
      ST_AMP,
      ST_DIV,
      ST_JIT,
      ST_MOD,
      ST_OUT
   } state_type;

   // request index from zoom in sixteenths, clamped to 12..16
   function automatic logic [7:0] zoom_req(input logic [7:0] z);
      logic [7:0] c;
      c = (z < 8'd12) ? 8'd12 : ((z > 8'd16) ? 8'd16 : z);
      return {c[3:0] - 4'd8, 4'd0};
   endfunction

endpackage

### hw/rtl/camera_follow_zoom_shake_top.sv
// Top level of the camera follow/zoom/shake view controller.
// Depends on cfzs_pkg.
//
// One word in, one word out. A tick runs two visible size divisions, follow
// and clamp when a point is tracked, and while shaking an amplitude division
// plus two jitter modulos, all on one serial shift-subtract divider and one
// multiplier under a small sequencer. Other modes go straight to the result
// word. Ready is low from acceptance until the result word has been taken.
module camera_follow_zoom_shake_top
   import cfzs_pkg::*;
#(
   parameter int SCREEN_W   = 320,
   parameter int SCREEN_H   = 224,
   parameter int HEIGHT_CAP = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic               req_track_valid,
   input  logic [7:0]         req_zoom_value,
   input  logic [7:0]         req_shake_strength,
   input  logic [7:0]         req_shake_frames,
   input  logic signed [31:0] req_new_x,
   input  logic signed [31:0] req_new_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_view_x,
   output logic signed [31:0] rsp_view_y,
   output logic signed [31:0] rsp_render_x,
   output logic signed [31:0] rsp_render_y,
   output logic [4:0]         rsp_zoom_now,
   output logic               rsp_zooming,
   output logic               rsp_shaking,
   output logic [15:0]        rsp_visible_width,
   output logic [15:0]        rsp_visible_height,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [16:0]        csr_write_data
);

   localparam logic [17:0] VW_NUM = 18'(SCREEN_W * 16);
   localparam logic [17:0] VH_NUM = 18'(SCREEN_H * 16);
   localparam logic [15:0] HCAP   = 16'(HEIGHT_CAP);

   // visible size per zoom level, entry k is zoom 8 + k
   localparam logic [15:0][15:0] VIS_W_TAB = {
      16'(VW_NUM / 23), 16'(VW_NUM / 22), 16'(VW_NUM / 21), 16'(VW_NUM / 20),
      16'(VW_NUM / 19), 16'(VW_NUM / 18), 16'(VW_NUM / 17), 16'(VW_NUM / 16),
      16'(VW_NUM / 15), 16'(VW_NUM / 14), 16'(VW_NUM / 13), 16'(VW_NUM / 12),
      16'(VW_NUM / 11), 16'(VW_NUM / 10), 16'(VW_NUM / 9),  16'(VW_NUM / 8)
   };
   localparam logic [15:0][15:0] VIS_H_TAB = {
      16'(VH_NUM / 23), 16'(VH_NUM / 22), 16'(VH_NUM / 21), 16'(VH_NUM / 20),
      16'(VH_NUM / 19), 16'(VH_NUM / 18), 16'(VH_NUM / 17), 16'(VH_NUM / 16),
      16'(VH_NUM / 15), 16'(VH_NUM / 14), 16'(VH_NUM / 13), 16'(VH_NUM / 12),
      16'(VH_NUM / 11), 16'(VH_NUM / 10), 16'(VH_NUM / 9),  16'(VH_NUM / 8)
   };

   // configuration
   logic [15:0] dz_w_ff, dz_h_ff, bnd_w_ff, bnd_h_ff, aim_x_ff, aim_y_ff;
   logic [16:0] gain_ff;
   logic [5:0]  zstep_ff;

   // state
   logic [31:0] pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic [7:0]  zidx_ff, zidx_in, zgoal_ff, zgoal_in;
   logic [7:0]  peak_ff, peak_in, slen_ff, slen_in, sleft_ff, sleft_in;
   logic [7:0]  jit_x_ff, jit_x_in, jit_y_ff, jit_y_in;
   logic [15:0] seed_ff, seed_in;

   // captured request
   logic [31:0] pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic        trk_ff, trk_in, jy_ff, jy_in;

   // working values
   logic [15:0] vw_ff, vw_in, vh_ff, vh_in;
   logic [8:0]  amp_ff, amp_in;
   logic signed [8:0] r_ff, r_in;

   // shared serial divider: unsigned remainder/quotient, one bit a cycle
   logic [17:0] dv_num_ff, dv_num_in, dv_rem_ff, dv_rem_in;
   logic [17:0] dv_den_ff, dv_den_in;
   logic [4:0]  dv_cnt_ff, dv_cnt_in;

   state_type state_ff, state_in;

   // shared multiplier: 33 x 18 signed
   logic signed [32:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [50:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic [4:0]  zoom;
   assign zoom = 5'd8 + {1'b0, zidx_ff[7:4]};

   // follow path for selected axis
   logic [31:0] cen, dlt, aim;
   logic [15:0] dzh;
   logic signed [32:0] half, sd, mv;
   always_comb begin
      if (state_ff == ST_MULY) begin
         cen  = pos_y_ff + {1'b0, vh_ff[15:1], 16'd0};
         aim  = {aim_y_ff, 16'd0};
         dlt  = pt_y_ff + aim - cen;
         dzh  = {1'b0, dz_h_ff[15:1]};
      end else begin
         cen  = pos_x_ff + {1'b0, vw_ff[15:1], 16'd0};
         aim  = {aim_x_ff, 16'd0};
         dlt  = pt_x_ff + aim - cen;
         dzh  = {1'b0, dz_w_ff[15:1]};
      end
      half = $signed({1'b0, dzh, 16'd0});
      sd   = $signed({dlt[31], dlt});
      if (sd > half)       mv = sd - half;
      else if (sd < -half) mv = sd + half;
      else                 mv = '0;
      mul_a = mv;
      mul_b = $signed({1'b0, gain_ff});
   end

   logic [31:0] step_mv;
   assign step_mv = mul_p[47:16];

   // clamp helpers
   function automatic logic [31:0] clamp_ax(input logic [31:0] p,
                                            input logic [15:0] b,
                                            input logic [15:0] v);
      logic signed [17:0] lim;
      logic [14:0] l;
      lim = $signed({2'b0, b}) - $signed({2'b0, v});
      l = (lim < 0) ? 15'd0 : ((lim > 18'sd32767) ? 15'h7FFF : lim[14:0]);
      if (p[31]) return 32'd0;
      if (p > {1'b0, l, 16'd0}) return {1'b0, l, 16'd0};
      return p;
   endfunction

   // divider step
   logic [17:0] dv_trial;
   logic [18:0] dv_sub;
   assign dv_trial = {dv_rem_ff[16:0], dv_num_ff[17]};
   assign dv_sub   = {1'b0, dv_trial} - {1'b0, dv_den_ff};

   logic [5:0]  zs;
   logic [8:0]  zn;
   logic [7:0]  zdn;
   logic [15:0] bh;
   logic [7:0]  sl_dec;
   logic [15:0] lcg;
   logic signed [9:0] jv;
   logic [8:0]  modd;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = (req_mode == MODE_TICK) ? ST_ZOOM : ST_OUT;
         ST_ZOOM:  state_in = ST_VIS;
         ST_VIS:   if (dv_cnt_ff == 5'd0 && jy_ff) state_in = trk_ff ? ST_MULX : ST_AMP;
         ST_MULX:  state_in = ST_MULY;
         ST_MULY:  state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_AMP;
         ST_AMP:   state_in = (sleft_ff != 8'd0) ? ST_DIV : ST_OUT;
         ST_DIV:   if (dv_cnt_ff == 5'd0) state_in = ST_JIT;
         ST_JIT:   state_in = ST_MOD;
         ST_MOD:   if (dv_cnt_ff == 5'd0) state_in = jy_ff ? ST_OUT : ST_JIT;
         ST_OUT:   if (rsp_ready && rsp_valid) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pos_x_in = pos_x_ff; pos_y_in = pos_y_ff;
      zidx_in = zidx_ff; zgoal_in = zgoal_ff;
      peak_in = peak_ff; slen_in = slen_ff; sleft_in = sleft_ff;
      jit_x_in = jit_x_ff; jit_y_in = jit_y_ff; seed_in = seed_ff;
      pt_x_in = pt_x_ff; pt_y_in = pt_y_ff; trk_in = trk_ff;
      jy_in = jy_ff;
      vw_in = vw_ff; vh_in = vh_ff; amp_in = amp_ff; r_in = r_ff;
      dv_num_in = dv_num_ff; dv_rem_in = dv_rem_ff; dv_den_in = dv_den_ff;
      dv_cnt_in = dv_cnt_ff;
      zs = (zstep_ff == 6'd0) ? 6'd1 : ((zstep_ff > 6'd32) ? 6'd32 : zstep_ff);
      zn = {1'b0, zidx_ff} + {3'd0, zs};
      zdn = (zidx_ff >= {2'd0, zs}) ? zidx_ff - {2'd0, zs} : 8'd0;
      bh = (bnd_h_ff > HCAP) ? HCAP : bnd_h_ff;
      sl_dec = sleft_ff - 8'd1;
      lcg = 16'(seed_ff * LCG_MUL[15:0]) + LCG_ADD;
      jv = '0;
      modd = {amp_ff[7:0], 1'b1};

      // divider iteration (shared)
      if ((state_ff == ST_VIS || state_ff == ST_DIV || state_ff == ST_MOD)
          && dv_cnt_ff != 5'd0) begin
         dv_cnt_in = dv_cnt_ff - 5'd1;
         dv_num_in = {dv_num_ff[16:0], ~dv_sub[18]};
         dv_rem_in = dv_sub[18] ? dv_trial : dv_sub[17:0];
      end

      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            pt_x_in = req_point_x; pt_y_in = req_point_y; trk_in = req_track_valid;
            unique case (req_mode)
               MODE_SHAKE: begin
                  peak_in = req_shake_strength; slen_in = req_shake_frames;
                  sleft_in = req_shake_frames;
               end
               MODE_STOP:   begin sleft_in = '0; jit_x_in = '0; jit_y_in = '0; end
               MODE_TARGET: zgoal_in = zoom_req(req_zoom_value);
               MODE_JUMP:   begin
                  zgoal_in = zoom_req(req_zoom_value);
                  zidx_in = zoom_req(req_zoom_value);
               end
               MODE_SETPOS: begin pos_x_in = req_new_x; pos_y_in = req_new_y; end
               default: ;
            endcase
         end
         ST_ZOOM: begin
            if (zidx_ff < zgoal_ff)
               zidx_in = (zn > {1'b0, zgoal_ff}) ? zgoal_ff : zn[7:0];
            else if (zidx_ff > zgoal_ff)
               zidx_in = (zdn < zgoal_ff) ? zgoal_ff : zdn;
            jy_in = 1'b0;
            // visible size is taken at the ramped zoom
            dv_num_in = VW_NUM; dv_rem_in = '0;
            dv_den_in = {13'd0, 5'd8 + {1'b0, zidx_in[7:4]}};
            dv_cnt_in = 5'd18;
         end
         ST_VIS: if (dv_cnt_ff == 5'd0) begin
            if (!jy_ff) begin
               vw_in = dv_num_ff[15:0]; jy_in = 1'b1;
               dv_num_in = VH_NUM; dv_rem_in = '0; dv_cnt_in = 5'd18;
            end else vh_in = dv_num_ff[15:0];
         end
         ST_MULX:  pos_x_in = pos_x_ff + step_mv;
         ST_MULY:  pos_y_in = pos_y_ff + step_mv;
         ST_CLAMP: if (bnd_w_ff != 16'd0 || bnd_h_ff != 16'd0) begin
            pos_x_in = clamp_ax(pos_x_ff, bnd_w_ff, vw_ff);
            pos_y_in = clamp_ax(pos_y_ff, bh, vh_ff);
         end
         ST_AMP: begin
            if (sleft_ff == 8'd0) begin
               jit_x_in = '0; jit_y_in = '0;
            end else begin
               sleft_in = sl_dec;
               dv_num_in = {2'd0, 16'(peak_ff * sl_dec)};
               dv_rem_in = '0;
               dv_den_in = {10'd0, (slen_ff == 8'd0) ? 8'd1 : slen_ff};
               dv_cnt_in = 5'd18;
               jy_in = 1'b0;
            end
         end
         ST_DIV: if (dv_cnt_ff == 5'd0)
            amp_in = (dv_num_ff[8:0] == 9'd0 && sleft_ff != 8'd0) ? 9'd1 : dv_num_ff[8:0];
         ST_JIT: begin
            seed_in = lcg;
            r_in = $signed({lcg[15], lcg[15:8]});
            // |r| through the divider, sign restored afterwards
            dv_num_in = {lcg[15] ? 8'd0 - lcg[15:8] : lcg[15:8], 10'd0};
            dv_rem_in = '0;
            dv_den_in = {8'd0, 1'b0, modd};
            dv_cnt_in = 5'd8;
         end
         ST_MOD: if (dv_cnt_ff == 5'd0) begin
            jv = r_ff[8] ? -$signed({1'b0, dv_rem_ff[8:0]})
                         : $signed({1'b0, dv_rem_ff[8:0]});
            jv = jv - $signed({1'b0, amp_ff});
            if (jy_ff) jit_y_in = jv[7:0];
            else begin jit_x_in = jv[7:0]; jy_in = 1'b1; end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dz_w_ff <= 16'd64; dz_h_ff <= 16'd32; gain_ff <= 17'd9830;
         bnd_w_ff <= '0; bnd_h_ff <= '0; aim_x_ff <= '0; aim_y_ff <= '0;
         zstep_ff <= 6'd16;
         pos_x_ff <= '0; pos_y_ff <= '0;
         zidx_ff <= ZOOM_RESET; zgoal_ff <= ZOOM_RESET;
         peak_ff <= '0; slen_ff <= '0; sleft_ff <= '0;
         jit_x_ff <= '0; jit_y_ff <= '0; seed_ff <= SEED_RESET;
      end else begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in; pos_y_ff <= pos_y_in;
         zidx_ff <= zidx_in; zgoal_ff <= zgoal_in;
         peak_ff <= peak_in; slen_ff <= slen_in; sleft_ff <= sleft_in;
         jit_x_ff <= jit_x_in; jit_y_ff <= jit_y_in; seed_ff <= seed_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_DZ_W:  dz_w_ff  <= csr_write_data[15:0];
               REG_DZ_H:  dz_h_ff  <= csr_write_data[15:0];
               REG_GAIN:  gain_ff  <= csr_write_data;
               REG_BND_W: bnd_w_ff <= csr_write_data[15:0];
               REG_BND_H: bnd_h_ff <= csr_write_data[15:0];
               REG_AIM_X: aim_x_ff <= csr_write_data[15:0];
               REG_AIM_Y: aim_y_ff <= csr_write_data[15:0];
               REG_ZSTEP: zstep_ff <= csr_write_data[5:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pt_x_ff <= pt_x_in; pt_y_ff <= pt_y_in; trk_ff <= trk_in;
      jy_ff <= jy_in;
      vw_ff <= vw_in; vh_ff <= vh_in; amp_ff <= amp_in; r_ff <= r_in;
      dv_num_ff <= dv_num_in; dv_rem_ff <= dv_rem_in; dv_den_ff <= dv_den_in;
      dv_cnt_ff <= dv_cnt_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = (state_ff == ST_OUT);
   assign rsp_view_x         = pos_x_ff;
   assign rsp_view_y         = pos_y_ff;
   assign rsp_render_x       = pos_x_ff + {{8{jit_x_ff[7]}}, jit_x_ff, 16'd0};
   assign rsp_render_y       = pos_y_ff + {{8{jit_y_ff[7]}}, jit_y_ff, 16'd0};
   assign rsp_zoom_now       = zoom;
   assign rsp_zooming        = (zidx_ff != zgoal_ff);
   assign rsp_shaking        = (sleft_ff != 8'd0);
   // visible size from a small constant table per zoom level
   assign rsp_visible_width  = VIS_W_TAB[zidx_ff[7:4]];
   assign rsp_visible_height = VIS_H_TAB[zidx_ff[7:4]];

endmodule
